// ===== design/srcc_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the sensor reply checker.
`timescale 1ns / 1ps

package srcc_pkg;

    // CRC-8, x^8+x^5+x^4+1, no reflection, zero seed
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Conversion scale factors (code * MUL) >> 16, then minus offset
    localparam logic [14:0] T_MUL = 15'd17572;
    localparam logic [14:0] H_MUL = 15'd12500;
    localparam logic [15:0] T_OFF = 16'd4685;
    localparam logic [15:0] H_OFF = 16'd600;

    // Measurement kind codes
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    localparam int CODE_W  = 16;
    localparam int VALUE_W = 15;
    localparam int PROD_W  = 31;

    // Frame tracker status for the item at the head of the input register
    typedef struct packed {
        logic              emit;    // this item closes a frame and gives a result
        logic              crc_ok;  // check byte equals computed CRC
        logic              kind;    // latched measurement kind
        logic [CODE_W-1:0] code;    // assembled measurement code
    } srcc_check_t;

    // One byte through the CRC-8 register, msb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== design/srcc_frame.sv =====
// Frame tracker: byte position, running CRC and stored code bytes.
`timescale 1ns / 1ps

module srcc_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,        // item in the input register is consumed
    input  logic [7:0]           rx_byte,
    input  logic                 func,
    input  logic                 first_byte,
    output srcc_pkg::srcc_check_t chk
);

    // Byte position codes
    localparam logic [1:0] POS_IDLE  = 2'd0;
    localparam logic [1:0] POS_LOW   = 2'd1;
    localparam logic [1:0] POS_CHECK = 2'd2;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       kind_reg, kind_next;
    logic [7:0] code_high_reg;
    logic [7:0] code_low_reg;
    logic       load_high;
    logic       load_low;

    // Status for the current item
    always_comb begin
        chk.emit   = !first_byte && (pos_reg == POS_CHECK);
        chk.crc_ok = (rx_byte == crc_reg);
        chk.kind   = kind_reg;
        chk.code   = {code_high_reg, code_low_reg};
    end

    // Next-state logic
    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        kind_next = kind_reg;
        load_high = 1'b0;
        load_low  = 1'b0;
        if (first_byte) begin
            pos_next  = POS_LOW;
            crc_next  = srcc_pkg::crc8_update(srcc_pkg::CRC_INIT, rx_byte);
            kind_next = func;
            load_high = 1'b1;
        end else begin
            case (pos_reg)
                POS_LOW: begin
                    pos_next = POS_CHECK;
                    crc_next = srcc_pkg::crc8_update(crc_reg, rx_byte);
                    load_low = 1'b1;
                end
                POS_CHECK: begin
                    pos_next = POS_IDLE;
                    crc_next = srcc_pkg::CRC_INIT;
                end
                default: begin
                    // stray byte with no frame open: ignored
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_IDLE;
            crc_reg  <= srcc_pkg::CRC_INIT;
            kind_reg <= srcc_pkg::KIND_TEMP;
        end else if (step) begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            kind_reg <= kind_next;
        end
    end

    // Code byte storage
    always_ff @(posedge aclk) begin
        if (step && load_high) begin
            code_high_reg <= rx_byte;
        end
        if (step && load_low) begin
            code_low_reg <= rx_byte;
        end
    end

    // Closing a frame always returns to idle with a cleared CRC
    a_close_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chk.emit) |=> (pos_reg == POS_IDLE && crc_reg == srcc_pkg::CRC_INIT))
        else $error("frame not closed after check byte");

    // A first byte always opens a frame at the low byte
    a_first_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && first_byte) |=> (pos_reg == POS_LOW))
        else $error("first byte did not restart frame");

endmodule

// ===== design/srcc_conv.sv =====
// Code to hundredths conversion: scale multiply, shift, offset, CRC gating.
`timescale 1ns / 1ps

module srcc_conv (
    input  srcc_pkg::srcc_check_t              chk,
    output logic signed [srcc_pkg::VALUE_W-1:0] value
);

    logic [14:0]                  mul;
    logic [15:0]                  off;
    logic [srcc_pkg::PROD_W-1:0]  product;
    logic [15:0]                  diff;

    // Scale select by kind
    always_comb begin
        if (chk.kind == srcc_pkg::KIND_HUM) begin
            mul = srcc_pkg::H_MUL;
            off = srcc_pkg::H_OFF;
        end else begin
            mul = srcc_pkg::T_MUL;
            off = srcc_pkg::T_OFF;
        end
    end

    // code * mul fits in 31 bits; keep the upper 15 after the >> 16
    assign product = {15'd0, chk.code} * {16'd0, mul};
    assign diff    = {1'b0, product[30:16]} - off;
    assign value   = chk.crc_ok ? $signed(diff[14:0]) : '0;

endmodule

// ===== design/sensor_reply_crc_check_convert_unit.sv =====
// Top level: input register, frame tracker, converter and result register.
//
//  channel | ports     | tdata                    | tuser
//  --------+-----------+--------------------------+---------------------------
//  input   | s_t*      | [7:0] rx_byte            | [0] func, [1] first_byte
//  result  | m_t*      | [14:0] value, [15] zero  | [0] crc_ok, [1] kind
//
// One item per cycle is taken unless a stalled result holds the input side; a
// check byte's result goes from the input register to the result register.
// Reset (aresetn low, synchronous) empties both registers and the frame.
// A stalled result holds the input side only when the next item would also
// give a result; bytes that give none keep flowing past it.
`timescale 1ns / 1ps

module sensor_reply_crc_check_convert_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [0] func, [1] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] value, [15] zero fill
    output logic [1:0]  m_tuser    // [0] crc_ok, [1] kind
);

    logic                               in_valid_reg, in_valid_next;
    logic [7:0]                         in_byte_reg;
    logic                               in_func_reg;
    logic                               in_first_reg;
    logic                               out_valid_reg, out_valid_next;
    logic signed [srcc_pkg::VALUE_W-1:0] out_value_reg;
    logic                               out_ok_reg;
    logic                               out_kind_reg;

    srcc_pkg::srcc_check_t               chk;
    logic signed [srcc_pkg::VALUE_W-1:0] value;
    logic                               out_free;
    logic                               step;
    logic                               s_take;

    // Handshake
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!chk.emit || out_free);
    assign s_tready = !in_valid_reg || step;
    assign s_take   = s_tvalid && s_tready;

    // Input register
    assign in_valid_next = s_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_tdata;
            in_func_reg  <= s_tuser[0];
            in_first_reg <= s_tuser[1];
        end
    end

    srcc_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .func       (in_func_reg),
        .first_byte (in_first_reg),
        .chk        (chk)
    );

    srcc_conv u_conv (
        .chk   (chk),
        .value (value)
    );

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && chk.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && chk.emit) begin
            out_value_reg <= value;
            out_ok_reg    <= chk.crc_ok;
            out_kind_reg  <= chk.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = {out_kind_reg, out_ok_reg};

    // A closing item always lands in the result register
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chk.emit) |=> out_valid_reg)
        else $error("result lost");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_valid_reg && !m_tready && step && chk.emit))
        else $error("pending result overwritten");

    // A failed check always carries a zero value
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ok_reg) |-> (out_value_reg == '0))
        else $error("nonzero value on crc failure");

    // A new result appears only from a closing item
    a_rise_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(step && chk.emit))
        else $error("result without closing item");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sensor reply CRC check and conversion unit.
`timescale 1ns / 1ps

module tb;

    // Byte position inside a reply frame
    localparam logic [1:0] POS_HIGH  = 2'd0;
    localparam logic [1:0] POS_LOW   = 2'd1;
    localparam logic [1:0] POS_CHECK = 2'd2;

    localparam logic [7:0]  CRC8_POLY  = 8'h31;
    localparam logic [31:0] TEMP_GAIN  = 32'd17572;
    localparam logic [31:0] HUM_GAIN   = 32'd12500;
    localparam int          TEMP_SHIFT = 4685;
    localparam int          HUM_SHIFT  = 600;

    localparam int RANDOM_BYTES = 1900;
    localparam int IDLE_PCT     = 21;
    localparam int CALM_START   = 1000;
    localparam int CALM_END     = 1600;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic       first;
        logic       func;
        logic [7:0] rx;
    } reply_byte_t;

    typedef struct packed {
        logic [14:0] value;
        logic        crc_ok;
        logic        kind;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic [1:0]  s_tuser;   // [0] func, [1] first_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [14:0] value, [15] zero fill
    logic [1:0]  m_tuser;   // [0] crc_ok, [1] kind

    reply_byte_t reply_bytes[$];
    reading_t    readings_due[$];

    // predictor state
    logic [1:0]  frame_pos;
    logic [7:0]  frame_crc;
    logic [7:0]  frame_high;
    logic [7:0]  frame_low;
    logic        frame_kind;

    int  errors;
    int  cycles;
    int  bytes_made;
    int  readings_seen;
    int  crc_rejects;
    int  restarts;
    int  strays;
    bit  s_fire;
    bit  calm;

    sensor_reply_crc_check_convert_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // CRC-8 one bit at a time, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    // code to signed hundredths, truncated to the 15-bit result field
    function automatic logic [14:0] scale_reading(input logic [15:0] code, input logic kind);
        logic [31:0] prod;
        int          v;
        if (kind == srcc_pkg::KIND_HUM) begin
            prod = 32'(code) * HUM_GAIN;
            v = int'(prod >> 16) - HUM_SHIFT;
        end else begin
            prod = 32'(code) * TEMP_GAIN;
            v = int'(prod >> 16) - TEMP_SHIFT;
        end
        return v[14:0];
    endfunction

    // frame tracker: updates state per accepted byte, queues the reading due
    function automatic void track_reply_byte(input reply_byte_t b);
        reading_t r;
        if (b.first) begin
            if (frame_pos != POS_HIGH)
                restarts++;
            frame_high = b.rx;
            frame_kind = b.func;
            frame_crc  = crc8_next(8'h00, b.rx);
            frame_pos  = POS_LOW;
        end else if (frame_pos == POS_LOW) begin
            frame_low = b.rx;
            frame_crc = crc8_next(frame_crc, b.rx);
            frame_pos = POS_CHECK;
        end else if (frame_pos == POS_CHECK) begin
            r.crc_ok = (b.rx == frame_crc);
            r.kind   = frame_kind;
            r.value  = r.crc_ok ? scale_reading({frame_high, frame_low}, frame_kind) : 15'd0;
            if (!r.crc_ok)
                crc_rejects++;
            readings_due.push_back(r);
            frame_pos = POS_HIGH;
            frame_crc = 8'h00;
        end else begin
            strays++;
        end
    endfunction

    // stimulus builders
    function automatic void add_byte(input logic [7:0] rx, input logic func, input logic first);
        reply_byte_t b;
        b.rx    = rx;
        b.func  = func;
        b.first = first;
        reply_bytes.push_back(b);
        bytes_made++;
    endfunction

    function automatic void add_stray(input logic [7:0] rx, input logic func);
        reply_byte_t b;
        b.rx    = rx;
        b.func  = func;
        b.first = 1'b0;
        reply_bytes.push_back(b);
    endfunction

    // full frame; a corrupted frame gets a check byte that is surely wrong
    function automatic void add_frame(input logic [15:0] code, input logic kind,
                                      input bit corrupt);
        logic [7:0] crc;
        crc = crc8_next(crc8_next(8'h00, code[15:8]), code[7:0]);
        if (corrupt)
            crc ^= 8'($urandom_range(1, 255));
        add_byte(code[15:8], kind, 1'b1);
        add_byte(code[7:0], 1'($urandom_range(1)), 1'b0);
        add_byte(crc, 1'($urandom_range(1)), 1'b0);
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            3: return 16'hFF00 | 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    // sender: valid held until taken, random gaps outside the calm stretch
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            s_tvalid <= 1'b1;
        end else if (reply_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            reply_byte_t b;
            b = reply_bytes.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= b.rx;
            s_tuser  <= {b.first, b.func};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: random back-pressure outside the calm stretch
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // result checking and prediction on accepted items
    always @(posedge aclk) begin
        reading_t    want;
        reply_byte_t got_in;
        s_fire = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                readings_seen++;
                if (readings_due.size() == 0) begin
                    $error("unexpected result: value=%0d crc_ok=%0b kind=%0b",
                           $signed(m_tdata[14:0]), m_tuser[0], m_tuser[1]);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_tdata[14:0] !== want.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata[14:0]));
                        errors++;
                    end
                    if (m_tuser[0] !== want.crc_ok) begin
                        $error("crc_ok: expected %0b, got %0b", want.crc_ok, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== want.kind) begin
                        $error("kind: expected %0b, got %0b", want.kind, m_tuser[1]);
                        errors++;
                    end
                    if (m_tdata[15] !== 1'b0) begin
                        $error("zero fill: expected 0, got %0b", m_tdata[15]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                s_fire = 1'b1;
                got_in.rx    = s_tdata;
                got_in.func  = s_tuser[0];
                got_in.first = s_tuser[1];
                track_reply_byte(got_in);
            end
        end
    end

    // cycle count, calm stretch and timeout
    always @(posedge aclk) begin
        cycles++;
        calm = (cycles >= CALM_START) && (cycles < CALM_END);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, readings_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int r;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 2'b00;
        m_tready   = 1'b0;
        frame_pos  = POS_HIGH;
        frame_crc  = 8'h00;
        frame_high = 8'h00;
        frame_low  = 8'h00;
        frame_kind = srcc_pkg::KIND_TEMP;

        // directed: code extremes for both kinds, a bad check byte,
        // a stray byte with no frame open, restarts after high and low bytes
        add_frame(16'h0000, srcc_pkg::KIND_TEMP, 1'b0);
        add_frame(16'hFFFF, srcc_pkg::KIND_TEMP, 1'b0);
        add_frame(16'h0000, srcc_pkg::KIND_HUM, 1'b0);
        add_frame(16'hFFFF, srcc_pkg::KIND_HUM, 1'b0);
        add_frame(16'h6543, srcc_pkg::KIND_TEMP, 1'b1);
        add_stray(8'hA5, 1'b1);
        add_byte(8'h12, srcc_pkg::KIND_HUM, 1'b1);
        add_frame(16'h8000, srcc_pkg::KIND_HUM, 1'b0);
        add_byte(8'h34, srcc_pkg::KIND_TEMP, 1'b1);
        add_byte(8'h56, srcc_pkg::KIND_HUM, 1'b0);
        add_frame(16'h1310, srcc_pkg::KIND_TEMP, 1'b0);

        // random: mostly clean frames, some with bad CRC, truncated ones, strays
        while (bytes_made < RANDOM_BYTES + 25) begin
            r = $urandom_range(99);
            if (r < 75) begin
                add_frame(pick_code(), 1'($urandom_range(1)), $urandom_range(99) < 15);
            end else if (r < 88) begin
                add_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
                if ($urandom_range(1))
                    add_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
                add_frame(pick_code(), 1'($urandom_range(1)), $urandom_range(99) < 15);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 3))
                    add_stray(8'($urandom), 1'($urandom_range(1)));
            end else begin
                // random check byte: mostly a CRC failure, now and then a hit
                add_byte(8'($urandom), 1'($urandom_range(1)), 1'b1);
                add_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
                add_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
            end
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (reply_bytes.size() != 0 || s_tvalid || readings_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d readings (%0d with CRC mismatch) from %0d frame bytes",
                 readings_seen, crc_rejects, bytes_made);
        $display("covered %0d mid-frame restarts and %0d bytes with no frame open",
                 restarts, strays);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
